/* rtl/rfop_pkg.sv */
package rfop_pkg;

    localparam int SLOTS   = 256;
    localparam int WORD_W  = 32;
    localparam int PTR_W   = $clog2(SLOTS);
    localparam int LEN_W   = PTR_W + 1;
    localparam int REQ_W   = 2;
    localparam int STAT_W  = 2;
    localparam int OFF_W   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH = 2'd0,
        REQ_POP  = 2'd1,
        REQ_PEEK = 2'd2,
        REQ_NOP  = 2'd3
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_RANGE = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOCK_WHEN_FULL = 2'd0,
        CFG_CAPACITY       = 2'd1,
        CFG_UNUSED_2       = 2'd2,
        CFG_UNUSED_3       = 2'd3
    } t_cfg_idx;

endpackage

/* rtl/rfop_req_if.sv */
interface rfop_req_if;
    logic                           valid;
    logic                           ready;
    logic [rfop_pkg::REQ_W-1:0]     req_type;
    logic [rfop_pkg::WORD_W-1:0]    push_data;
    logic [rfop_pkg::OFF_W-1:0]     peek_offset;

    modport source (output valid, req_type, push_data, peek_offset, input ready);
    modport sink   (input valid, req_type, push_data, peek_offset, output ready);
endinterface

/* rtl/rfop_rsp_if.sv */
interface rfop_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [rfop_pkg::STAT_W-1:0]    status;
    logic [rfop_pkg::WORD_W-1:0]    read_data;
    logic                           dropped_oldest;

    modport source (output valid, status, read_data, dropped_oldest, input ready);
    modport sink   (input valid, status, read_data, dropped_oldest, output ready);
endinterface

/* rtl/ring_fifo_overwrite_peek.sv */
// Channel  | Dir | Handshake    | Payload
// i_req    | in  | valid/ready  | req_type, push_data, peek_offset
// o_rsp    | out | valid/ready  | status, read_data, dropped_oldest
// i_cfg_*  | in  | write enable | register index, write data
//
// Every request beat yields one response beat in the cycle after it; a new request
// is taken in every cycle while the response register is empty or drained.
// The read word comes from the single registered read port of the ring storage.
// Synchronous active-low reset empties the ring and loads lock off, capacity 255.
// A stalled response holds its register and its read word; requests wait.
module ring_fifo_overwrite_peek (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rfop_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [rfop_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    rfop_req_if.sink                            i_req,
    rfop_rsp_if.source                          o_rsp
);

    logic [rfop_pkg::WORD_W-1:0] r_mem [rfop_pkg::SLOTS];

    logic                           r_lock;
    logic [rfop_pkg::PTR_W-1:0]     r_cap_eff;
    logic [rfop_pkg::PTR_W-1:0]     r_head;
    logic [rfop_pkg::PTR_W-1:0]     r_tail;
    logic [rfop_pkg::PTR_W-1:0]     n_head;
    logic [rfop_pkg::PTR_W-1:0]     n_tail;

    logic                           r_out_valid;
    rfop_pkg::t_status              r_status;
    rfop_pkg::t_status              n_status;
    logic                           r_dropped;
    logic                           n_dropped;
    logic                           r_rd_sel;
    logic                           n_rd_sel;
    logic [rfop_pkg::WORD_W-1:0]    r_rd_data;

    logic                           accept;
    logic                           mem_we;
    logic [rfop_pkg::PTR_W-1:0]     rd_addr;
    logic [rfop_pkg::LEN_W-1:0]     ring_len;
    logic [rfop_pkg::LEN_W-1:0]     count;
    logic [rfop_pkg::LEN_W-1:0]     head_inc;
    logic [rfop_pkg::LEN_W-1:0]     tail_inc;
    logic [rfop_pkg::LEN_W-1:0]     peek_sum;
    logic [rfop_pkg::PTR_W-1:0]     head_adv;
    logic [rfop_pkg::PTR_W-1:0]     tail_adv;
    logic [rfop_pkg::PTR_W-1:0]     peek_addr;
    logic                           full;
    rfop_pkg::t_req                 req;

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;
    assign req         = rfop_pkg::t_req'(i_req.req_type);

    assign ring_len = {1'b0, r_cap_eff} + rfop_pkg::LEN_W'(1);
    assign head_inc = {1'b0, r_head} + rfop_pkg::LEN_W'(1);
    assign tail_inc = {1'b0, r_tail} + rfop_pkg::LEN_W'(1);
    assign head_adv = (head_inc >= ring_len) ? '0 : head_inc[rfop_pkg::PTR_W-1:0];
    assign tail_adv = (tail_inc >= ring_len) ? '0 : tail_inc[rfop_pkg::PTR_W-1:0];

    // Occupancy of the ring, with the wrap folded back by one ring length.
    assign count = (r_tail >= r_head)
                 ? ({1'b0, r_tail} - {1'b0, r_head})
                 : ({1'b0, r_tail} + ring_len - {1'b0, r_head});
    assign full  = (count == {1'b0, r_cap_eff});

    assign peek_sum  = {1'b0, r_head} + rfop_pkg::LEN_W'(i_req.peek_offset);
    assign peek_addr = (peek_sum >= ring_len) ? rfop_pkg::PTR_W'(peek_sum - ring_len)
                                              : peek_sum[rfop_pkg::PTR_W-1:0];

    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_status  = rfop_pkg::STAT_OK;
        n_dropped = 1'b0;
        n_rd_sel  = 1'b0;
        mem_we    = 1'b0;
        rd_addr   = r_head;
        case (req)
            rfop_pkg::REQ_PUSH: begin
                if (full && r_lock) begin
                    n_status = rfop_pkg::STAT_FULL;
                end else begin
                    // Overwrite mode: the oldest entry gives way to the new word.
                    if (full) begin
                        n_head    = head_adv;
                        n_dropped = 1'b1;
                    end
                    mem_we = 1'b1;
                    n_tail = tail_adv;
                end
            end
            rfop_pkg::REQ_POP: begin
                if (count == '0) begin
                    n_status = rfop_pkg::STAT_EMPTY;
                end else begin
                    n_rd_sel = 1'b1;
                    n_head   = head_adv;
                end
            end
            rfop_pkg::REQ_PEEK: begin
                if (rfop_pkg::LEN_W'(i_req.peek_offset) >= count) begin
                    n_status = rfop_pkg::STAT_RANGE;
                end else begin
                    n_rd_sel = 1'b1;
                    rd_addr  = peek_addr;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lock      <= 1'b0;
            r_cap_eff   <= rfop_pkg::PTR_W'(rfop_pkg::SLOTS - 1);
            r_head      <= '0;
            r_tail      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_head <= n_head;
                r_tail <= n_tail;
            end
            if (i_cfg_we) begin
                case (rfop_pkg::t_cfg_idx'(i_cfg_idx))
                    rfop_pkg::CFG_LOCK_WHEN_FULL: begin
                        r_lock <= i_cfg_data[0];
                    end
                    rfop_pkg::CFG_CAPACITY: begin
                        // A capacity of zero behaves as one; the ring is emptied.
                        r_cap_eff <= (i_cfg_data == '0) ? rfop_pkg::PTR_W'(1)
                                                        : i_cfg_data;
                        r_head    <= '0;
                        r_tail    <= '0;
                    end
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status  <= n_status;
            r_dropped <= n_dropped;
            r_rd_sel  <= n_rd_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && mem_we) begin
            r_mem[r_tail] <= i_req.push_data;
        end
        if (accept && n_rd_sel) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_status;
    assign o_rsp.read_data      = r_rd_sel ? r_rd_data : '0;
    assign o_rsp.dropped_oldest = r_dropped;

endmodule

/* rtl/rfop_checker.sv */
module rfop_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [rfop_pkg::REQ_W-1:0]      i_req_type,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [rfop_pkg::STAT_W-1:0]     i_status,
    input  logic [rfop_pkg::WORD_W-1:0]     i_read_data,
    input  logic                            i_dropped_oldest
);

    logic in_beat;
    assign in_beat = i_in_valid && i_in_ready;

    // An empty response register never holds back requests.
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("request side stalled with no response pending");

    a_beat_gives_response: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> i_out_valid)
        else $error("request beat produced no response");

    a_push_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && (i_req_type == rfop_pkg::REQ_PUSH) |=>
            (i_status == rfop_pkg::STAT_OK || i_status == rfop_pkg::STAT_FULL)
            && (i_read_data == '0))
        else $error("push answered with a read status or data");

    a_pop_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && (i_req_type == rfop_pkg::REQ_POP) |=>
            !i_dropped_oldest
            && (i_status == rfop_pkg::STAT_OK || i_status == rfop_pkg::STAT_EMPTY))
        else $error("pop answered with a push status or drop flag");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_status) && $stable(i_read_data)
            && $stable(i_dropped_oldest))
        else $error("stalled response changed");

endmodule

bind ring_fifo_overwrite_peek rfop_checker u_rfop_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_req.valid),
    .i_in_ready       (i_req.ready),
    .i_req_type       (i_req.req_type),
    .i_out_valid      (o_rsp.valid),
    .i_out_ready      (o_rsp.ready),
    .i_status         (o_rsp.status),
    .i_read_data      (o_rsp.read_data),
    .i_dropped_oldest (o_rsp.dropped_oldest)
);

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    typedef struct packed {
        logic [rfop_pkg::STAT_W-1:0] status;
        logic [rfop_pkg::WORD_W-1:0] read_data;
        logic                        dropped;
    } t_fifo_rsp;

    localparam int CYCLE_LIMIT = 300000;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [rfop_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [rfop_pkg::CFG_DATA_W-1:0] i_cfg_data;

    rfop_req_if req_if();
    rfop_rsp_if rsp_if();

    ring_fifo_overwrite_peek u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the ring, its pointers and its registers.
    logic [rfop_pkg::WORD_W-1:0]     ring_mem [rfop_pkg::SLOTS];
    int unsigned                     ring_head;
    int unsigned                     ring_tail;
    logic                            shadow_lock;
    logic [rfop_pkg::CFG_DATA_W-1:0] shadow_cap;

    t_fifo_rsp   results_due[$];
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    bit          steady_run = 1'b0;

    function automatic int unsigned ring_slots();
        int unsigned c;
        c = shadow_cap;
        if (c < 1) c = 1;
        if (c > rfop_pkg::SLOTS - 1) c = rfop_pkg::SLOTS - 1;
        return c + 1;
    endfunction

    function automatic int unsigned ring_next(int unsigned idx, int unsigned n);
        return (idx + 1 >= n) ? 0 : idx + 1;
    endfunction

    function automatic int unsigned fifo_count();
        int unsigned n;
        n = ring_slots();
        return (ring_tail + n - ring_head) % n;
    endfunction

    function automatic t_fifo_rsp fifo_apply(rfop_pkg::t_req kind,
                                             logic [rfop_pkg::WORD_W-1:0] word,
                                             logic [rfop_pkg::OFF_W-1:0] off);
        t_fifo_rsp   r;
        int unsigned n;
        int unsigned cnt;
        bit          full;
        n = ring_slots();
        if (ring_head >= n) ring_head = 0;
        if (ring_tail >= n) ring_tail = 0;
        cnt = (ring_tail + n - ring_head) % n;
        r = '0;
        r.status = rfop_pkg::STAT_OK;
        case (kind)
            rfop_pkg::REQ_PUSH: begin
                full = (ring_next(ring_tail, n) == ring_head);
                if (full && shadow_lock) begin
                    r.status = rfop_pkg::STAT_FULL;
                end else begin
                    if (full) begin
                        ring_head = ring_next(ring_head, n);
                        r.dropped = 1'b1;
                    end
                    ring_mem[ring_tail] = word;
                    ring_tail = ring_next(ring_tail, n);
                end
            end
            rfop_pkg::REQ_POP: begin
                if (cnt == 0) begin
                    r.status = rfop_pkg::STAT_EMPTY;
                end else begin
                    r.read_data = ring_mem[ring_head];
                    ring_head = ring_next(ring_head, n);
                end
            end
            rfop_pkg::REQ_PEEK: begin
                if (off >= cnt) begin
                    r.status = rfop_pkg::STAT_RANGE;
                end else begin
                    r.read_data = ring_mem[(ring_head + off) % n];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic void shadow_write(rfop_pkg::t_cfg_idx idx,
                                         logic [rfop_pkg::CFG_DATA_W-1:0] value);
        case (idx)
            rfop_pkg::CFG_LOCK_WHEN_FULL: shadow_lock = value[0];
            rfop_pkg::CFG_CAPACITY: begin
                shadow_cap = value;
                ring_head  = 0;
                ring_tail  = 0;
            end
            default: ;
        endcase
    endfunction

    // The sink stalls at random except during the steady stretch.
    always @(posedge i_clk) begin
        rsp_if.ready <= steady_run || ($urandom_range(99) >= 13);
    end

    always @(posedge i_clk) begin : check_rsp
        t_fifo_rsp want;
        if (i_rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response beat: status %0d read_data %h dropped %0d",
                             rsp_if.status, rsp_if.read_data, rsp_if.dropped_oldest);
            end else begin
                want = results_due.pop_front();
                if (rsp_if.status !== want.status || rsp_if.read_data !== want.read_data ||
                    rsp_if.dropped_oldest !== want.dropped) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp/got: status %0d/%0d, read_data %h/%h, dropped %0d/%0d",
                                 want.status, rsp_if.status, want.read_data,
                                 rsp_if.read_data, want.dropped, rsp_if.dropped_oldest);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Leaves valid high on return, so the caller must send again or go idle
    // in the same time step.
    task automatic send_req(rfop_pkg::t_req kind, logic [rfop_pkg::WORD_W-1:0] word = '0,
                            logic [rfop_pkg::OFF_W-1:0] off = '0);
        if (!steady_run && $urandom_range(99) < 13) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.req_type    <= kind;
        req_if.push_data   <= word;
        req_if.peek_offset <= off;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        results_due.push_back(fifo_apply(kind, word, off));
    endtask

    task automatic wait_idle();
        req_if.valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(rfop_pkg::t_cfg_idx idx,
                             logic [rfop_pkg::CFG_DATA_W-1:0] value);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        shadow_write(idx, value);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_reset_state();
        send_req(rfop_pkg::REQ_POP);
        send_req(rfop_pkg::REQ_PEEK, '0, 8'd0);
        send_req(rfop_pkg::REQ_NOP, 32'hFFFF_FFFF, 8'hFF);
        send_req(rfop_pkg::REQ_PUSH, 32'hFFFF_FFFF);
        send_req(rfop_pkg::REQ_PUSH, 32'h0000_0000);
        send_req(rfop_pkg::REQ_PEEK, '0, 8'd1);
        send_req(rfop_pkg::REQ_PEEK, '0, 8'd0);
        send_req(rfop_pkg::REQ_PEEK, '0, 8'd2);
        send_req(rfop_pkg::REQ_PEEK, '0, 8'hFF);
        send_req(rfop_pkg::REQ_POP);
        send_req(rfop_pkg::REQ_POP);
        send_req(rfop_pkg::REQ_POP);
    endtask

    // A capacity of zero behaves as one entry: overwrite, then refusal.
    task automatic test_single_entry();
        write_reg(rfop_pkg::CFG_CAPACITY, 8'h00);
        write_reg(rfop_pkg::CFG_LOCK_WHEN_FULL, 8'hFE);
        send_req(rfop_pkg::REQ_PUSH, 32'hA5A5_0001);
        send_req(rfop_pkg::REQ_PUSH, 32'h5A5A_0002);
        send_req(rfop_pkg::REQ_PEEK, '0, 8'd0);
        send_req(rfop_pkg::REQ_PEEK, '0, 8'd1);
        send_req(rfop_pkg::REQ_POP);
        write_reg(rfop_pkg::CFG_LOCK_WHEN_FULL, 8'h01);
        send_req(rfop_pkg::REQ_PUSH, 32'hC0DE_0003);
        send_req(rfop_pkg::REQ_PUSH, 32'hDEAD_0004);
        send_req(rfop_pkg::REQ_POP);
    endtask

    // Writes to unused indexes change nothing; a capacity write empties the ring.
    task automatic test_register_map();
        send_req(rfop_pkg::REQ_PUSH, 32'h1234_5678);
        write_reg(rfop_pkg::CFG_UNUSED_2, 8'hFF);
        write_reg(rfop_pkg::CFG_UNUSED_3, 8'h00);
        send_req(rfop_pkg::REQ_POP);
        send_req(rfop_pkg::REQ_PUSH, 32'h8765_4321);
        write_reg(rfop_pkg::CFG_CAPACITY, 8'hFF);
        send_req(rfop_pkg::REQ_POP);
    endtask

    task automatic run_traffic(int items, int push_pct, int pop_pct);
        int                          roll;
        int unsigned                 cnt;
        logic [rfop_pkg::WORD_W-1:0] word;
        logic [rfop_pkg::OFF_W-1:0]  off;
        rfop_pkg::t_req              kind;
        for (int i = 0; i < items; i++) begin
            case ($urandom_range(9))
                0: word = '0;
                1: word = '1;
                default: word = $urandom();
            endcase
            cnt = fifo_count();
            if (cnt > 0 && $urandom_range(99) < 80)
                off = rfop_pkg::OFF_W'($urandom_range(cnt - 1, 0));
            else if ($urandom_range(1) == 1)
                off = rfop_pkg::OFF_W'(cnt);
            else
                off = rfop_pkg::OFF_W'($urandom_range(255, 0));
            roll = $urandom_range(99);
            if (roll < 3)
                kind = rfop_pkg::REQ_NOP;
            else if (roll < 3 + push_pct)
                kind = rfop_pkg::REQ_PUSH;
            else if (roll < 3 + push_pct + pop_pct)
                kind = rfop_pkg::REQ_POP;
            else
                kind = rfop_pkg::REQ_PEEK;
            send_req(kind, word, off);
        end
    endtask

    task automatic test_random_traffic();
        write_reg(rfop_pkg::CFG_LOCK_WHEN_FULL, 8'h01);
        write_reg(rfop_pkg::CFG_CAPACITY, 8'h01);
        run_traffic(90, 50, 30);
        write_reg(rfop_pkg::CFG_LOCK_WHEN_FULL, 8'h00);
        write_reg(rfop_pkg::CFG_CAPACITY, 8'h00);
        run_traffic(80, 50, 30);
        write_reg(rfop_pkg::CFG_CAPACITY, 8'h03);
        run_traffic(100, 50, 30);
        write_reg(rfop_pkg::CFG_LOCK_WHEN_FULL, 8'hFF);
        write_reg(rfop_pkg::CFG_CAPACITY, 8'h10);
        steady_run <= 1'b1;
        run_traffic(150, 55, 25);
        wait_idle();
        steady_run <= 1'b0;
        write_reg(rfop_pkg::CFG_LOCK_WHEN_FULL, 8'h00);
        write_reg(rfop_pkg::CFG_CAPACITY, 8'h80);
        run_traffic(100, 45, 35);
        // Push-heavy until the full ring refuses, then let it overwrite.
        write_reg(rfop_pkg::CFG_LOCK_WHEN_FULL, 8'h01);
        write_reg(rfop_pkg::CFG_CAPACITY, 8'hFF);
        run_traffic(300, 92, 3);
        write_reg(rfop_pkg::CFG_LOCK_WHEN_FULL, 8'h00);
        run_traffic(130, 70, 20);
        write_reg(rfop_pkg::CFG_LOCK_WHEN_FULL, 8'h01);
        write_reg(rfop_pkg::CFG_CAPACITY, 8'h7F);
        run_traffic(100, 45, 35);
    endtask

    initial begin
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= rfop_pkg::CFG_LOCK_WHEN_FULL;
        i_cfg_data         <= '0;
        req_if.valid       <= 1'b0;
        req_if.req_type    <= rfop_pkg::REQ_NOP;
        req_if.push_data   <= '0;
        req_if.peek_offset <= '0;
        shadow_lock = 1'b0;
        shadow_cap  = 8'hFF;
        ring_head   = 0;
        ring_tail   = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_single_entry();
        test_register_map();
        test_random_traffic();

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && results_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
